// ===== rtl/core/ihyp_pkg.sv =====
// Package with the widths, stage record and defaults of the integer hypotenuse pipeline.
`timescale 1ns / 1ps

package ihyp_pkg;

   // Field widths
   localparam int DELTA_W = 16;
   localparam int DIST_W  = 16;
   localparam int MAG_W   = DELTA_W + 1;   // magnitude of the most negative delta needs one more bit
   localparam int SUM_W   = 32;            // sum of squares is at most 2^31
   localparam int ROOT_W  = 17;            // root estimate stays below 2^16, one bit of margin
   localparam int QUO_W   = 17;            // sum / root never exceeds 2^16
   localparam int DIV_W   = SUM_W + 2;     // room for root shifted by the top quotient bit

   // Default number of refinement steps
   localparam int NEWTON_STEPS_DEF = 3;

   // One slot of the refinement pipeline
   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [SUM_W-1:0]  sum;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } stage_type;

endpackage

// ===== rtl/core/integer_hypotenuse.sv =====
// Pipelined integer hypotenuse: sum of squares, linear guess and Newton refinement.
`timescale 1ns / 1ps
//
//  channel   dir   handshake              payload
//  req       in    req_tvalid/req_tready  req_tdata: delta_x [15:0], delta_y [31:16]
//  rsp       out   rsp_tvalid/rsp_tready  rsp_tdata: distance [15:0]
//
//  Throughput is one beat per cycle while the skid register is empty. The pipeline has
//  one stage each for magnitude, squares, sum, then per Newton step one long-division
//  stage per quotient bit plus one averaging stage, and the output register. Reset
//  clears the valid bits only; no clearing pass is needed. A stalled output parks one
//  beat in a skid register; req_tready then drops and the whole pipeline holds until
//  the skid register drains.
//
module integer_hypotenuse #(
   parameter int NEWTON_STEPS = ihyp_pkg::NEWTON_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // delta_x [15:0], delta_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // distance [15:0]
);
   import ihyp_pkg::*;

   localparam int SLOT_N  = QUO_W + 1;
   localparam int STAGE_N = NEWTON_STEPS * SLOT_N;

   // Pipeline advance: held only while the skid register is occupied
   logic run;

   // Stage 1: magnitudes
   logic             mag_valid_ff;
   logic [MAG_W-1:0] mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;

   // Stage 2: squares and first guess
   logic              sq_valid_ff;
   logic [SUM_W-1:0]  sq_x_ff, sq_y_ff;
   logic [ROOT_W-1:0] guess_ff, guess_in;
   logic [2*MAG_W-1:0] prod_x, prod_y;

   // Stage 3 and refinement slots
   stage_type        front_ff, front_in;
   logic [SUM_W:0]   sum_wide;
   stage_type        pipe_ff [STAGE_N];
   stage_type        pipe_in [STAGE_N];

   // Output register and skid register
   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DIST_W-1:0] skid_data_ff, skid_data_in;
   logic [DIST_W-1:0] last_dist;
   stage_type         last_stage;

   assign run        = !skid_valid_ff;
   assign req_tready = run;

   // Take magnitudes; the most negative value maps to 2^15 exactly
   always_comb begin
      mag_x_in = req_tdata[DELTA_W-1] ?
                 MAG_W'((MAG_W'(1) << DELTA_W) - {1'b0, req_tdata[DELTA_W-1:0]}) :
                 {1'b0, req_tdata[DELTA_W-1:0]};
      mag_y_in = req_tdata[2*DELTA_W-1] ?
                 MAG_W'((MAG_W'(1) << DELTA_W) - {1'b0, req_tdata[2*DELTA_W-1:DELTA_W]}) :
                 {1'b0, req_tdata[2*DELTA_W-1:DELTA_W]};
   end

   // Square and form the guess: larger magnitude plus half the smaller
   always_comb begin
      prod_x = mag_x_ff * mag_x_ff;
      prod_y = mag_y_ff * mag_y_ff;
      if (mag_x_ff > mag_y_ff) begin
         guess_in = ROOT_W'(mag_x_ff) + ROOT_W'(mag_y_ff >> 1);
      end else begin
         guess_in = ROOT_W'(mag_y_ff) + ROOT_W'(mag_x_ff >> 1);
      end
   end

   // Add the squares and load the first refinement slot
   always_comb begin
      sum_wide       = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      front_in.valid = sq_valid_ff;
      front_in.zero  = (guess_ff == '0);
      front_in.sum   = sum_wide[SUM_W-1:0];
      front_in.root  = guess_ff;
      front_in.rem   = sum_wide[SUM_W-1:0];
      front_in.quo   = '0;
   end

   // Refinement slots: one quotient bit each, then an averaging slot per step
   for (genvar k = 0; k < STAGE_N; k++) begin : g_slot
      localparam int SLOT = k % SLOT_N;
      stage_type src;
      assign src = (k == 0) ? front_ff : pipe_ff[(k == 0) ? 0 : k - 1];

      if (SLOT < QUO_W) begin : g_div
         localparam int BIT = QUO_W - 1 - SLOT;
         logic [DIV_W-1:0] shifted, rem_x;
         always_comb begin
            shifted    = DIV_W'(src.root) << BIT;
            rem_x      = DIV_W'(src.rem);
            pipe_in[k] = src;
            if (rem_x >= shifted) begin
               pipe_in[k].rem      = SUM_W'(rem_x - shifted);
               pipe_in[k].quo[BIT] = 1'b1;
            end
         end
      end else begin : g_avg
         logic [ROOT_W:0] avg;
         always_comb begin
            avg             = ({1'b0, src.quo} + {1'b0, src.root}) >> 1;
            pipe_in[k]      = src;
            pipe_in[k].root = avg[ROOT_W-1:0];
            pipe_in[k].zero = src.zero || (avg[ROOT_W-1:0] == '0);
            pipe_in[k].rem  = src.sum;
            pipe_in[k].quo  = '0;
         end
      end
   end

   // Advance the front stages and the refinement slots together
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff   <= 1'b0;
         sq_valid_ff    <= 1'b0;
         front_ff.valid <= 1'b0;
         for (int k = 0; k < STAGE_N; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (run) begin
         mag_valid_ff <= req_tvalid;
         mag_x_ff     <= mag_x_in;
         mag_y_ff     <= mag_y_in;
         sq_valid_ff  <= mag_valid_ff;
         sq_x_ff      <= prod_x[SUM_W-1:0];
         sq_y_ff      <= prod_y[SUM_W-1:0];
         guess_ff     <= guess_in;
         front_ff     <= front_in;
         for (int k = 0; k < STAGE_N; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Clamp the final root; a zero guess or a zero average gives zero
   always_comb begin
      last_stage = pipe_ff[STAGE_N-1];
      if (last_stage.zero) begin
         last_dist = '0;
      end else if (last_stage.root > ROOT_W'({DIST_W{1'b1}})) begin
         last_dist = {DIST_W{1'b1}};
      end else begin
         last_dist = last_stage.root[DIST_W-1:0];
      end
   end

   // Output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = last_stage.valid;
            out_data_in  = last_dist;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = last_stage.valid;
         out_data_in  = last_dist;
      end else if (run && last_stage.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = last_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output beat in front of it");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !skid_valid_ff))
      else $error("output side not empty after reset");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (last_stage.valid && !last_stage.zero) |-> (last_stage.root != '0))
      else $error("refined root collapsed to zero");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      (last_stage.valid && !last_stage.zero) |-> !last_stage.root[ROOT_W-1])
      else $error("refined root outside the expected range");

endmodule

// ===== sim/integer_hypotenuse_test.sv =====
// Self-checking stream testbench for the integer hypotenuse pipeline.
`timescale 1ns / 1ps

module integer_hypotenuse_test;
   import ihyp_pkg::*;

   localparam int REFINE_STEPS = NEWTON_STEPS_DEF;
   localparam int PIPE_DEPTH   = 4 + REFINE_STEPS * (QUO_W + 1);
   localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CALM_ITEMS   = 200;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;

   // One directed probe; the distance is used only where the row is typed
   typedef struct packed {
      logic [DELTA_W-1:0] delta_x;
      logic [DELTA_W-1:0] delta_y;
      logic               typed;
      logic [DIST_W-1:0]  distance;
   } probe_row_type;

   localparam int PROBES = 19;
   localparam probe_row_type DIRECTED [PROBES] = '{
      '{16'h0000,  16'h0000,  1'b1, 16'd0},       // both differences zero
      '{16'h0001,  16'h0000,  1'b1, 16'd1},
      '{16'h0000,  16'hFFFF,  1'b1, 16'd1},
      '{16'd3,     16'd4,     1'b1, 16'd5},
      '{-16'sd3,   -16'sd4,   1'b1, 16'd5},
      '{16'h7FFF,  16'h0000,  1'b1, 16'd32767},
      '{16'h8000,  16'h0000,  1'b1, 16'd32768},   // most negative delta, full magnitude
      '{16'h0000,  16'h8000,  1'b1, 16'd32768},
      '{16'h0000,  16'h7FFF,  1'b1, 16'd32767},
      '{16'h8000,  16'h8000,  1'b0, 16'd0},       // largest sum of squares
      '{16'h7FFF,  16'h7FFF,  1'b0, 16'd0},
      '{16'h8000,  16'h7FFF,  1'b0, 16'd0},
      '{16'h7FFF,  16'h8000,  1'b0, 16'd0},
      '{16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
      '{16'h0001,  16'h8000,  1'b0, 16'd0},
      '{16'h5555,  16'hAAAA,  1'b0, 16'd0},
      '{16'hAAAA,  16'h5555,  1'b0, 16'd0},
      '{16'd1,     16'd2,     1'b0, 16'd0},
      '{16'h8001,  16'h0003,  1'b0, 16'd0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // delta_x [15:0], delta_y [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // distance [15:0]

   logic [DIST_W-1:0] distance_due [$];
   int  fail_count;
   int  accepted_count;
   int  checked_count;
   int  zero_count;
   int  input_stall_cycles;
   bit  calm;

   integer_hypotenuse #(
      .NEWTON_STEPS(REFINE_STEPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sum of squares, linear starting guess, then Newton refinement
   function automatic logic [DIST_W-1:0] hypot_distance(input logic [DELTA_W-1:0] dx_raw,
                                                        input logic [DELTA_W-1:0] dy_raw);
      logic [DELTA_W:0] mag_x;
      logic [DELTA_W:0] mag_y;
      logic [SUM_W-1:0] squares;
      logic [SUM_W:0]   root;
      mag_x   = dx_raw[DELTA_W-1] ? (17'h10000 - {1'b0, dx_raw}) : {1'b0, dx_raw};
      mag_y   = dy_raw[DELTA_W-1] ? (17'h10000 - {1'b0, dy_raw}) : {1'b0, dy_raw};
      squares = SUM_W'(mag_x) * SUM_W'(mag_x) + SUM_W'(mag_y) * SUM_W'(mag_y);
      root    = (mag_x > mag_y) ? (SUM_W + 1)'(mag_x) + (mag_y >> 1)
                                : (SUM_W + 1)'(mag_y) + (mag_x >> 1);
      if (root == 0)
         return '0;
      for (int step = 0; step < REFINE_STEPS; step++) begin
         if (root == 0)
            return '0;
         root = ((SUM_W + 1)'(squares) / root + root) >> 1;
      end
      return (root > 'hFFFF) ? '1 : root[DIST_W-1:0];
   endfunction

   // Mix of full-range, small and near-extreme deltas
   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(0, 5))
         0: return DELTA_W'($urandom_range(0, 20));
         1: return DELTA_W'(0 - $urandom_range(1, 20));
         2: return 16'h8000 + DELTA_W'($urandom_range(0, 3));
         3: return 16'h7FFF - DELTA_W'($urandom_range(0, 3));
         default: return DELTA_W'($urandom());
      endcase
   endfunction

   // Offer one beat, with an occasional idle burst first; record its distance on acceptance
   task automatic drive_beat(input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy,
                             input logic [DIST_W-1:0] distance);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dy, dx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      distance_due.push_back(distance);
      accepted_count++;
   endtask

   // Stimulus: reset, directed probes, random deltas, drain, verdict
   initial begin
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         drive_beat(DIRECTED[i].delta_x, DIRECTED[i].delta_y,
                    DIRECTED[i].typed ? DIRECTED[i].distance
                                      : hypot_distance(DIRECTED[i].delta_x,
                                                       DIRECTED[i].delta_y));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         dx = pick_delta();
         dy = pick_delta();
         drive_beat(dx, dy, hypot_distance(dx, dy));
      end
      req_tvalid <= 1'b0;
      while (distance_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d delta pairs (%0d directed), %0d distances checked, %0d zero",
               accepted_count, PROBES, checked_count, zero_count);
      $display("input held off for %0d cycles under result backpressure", input_stall_cycles);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall bursts, one long hold-off to fill the pipeline
   initial begin
      bit hold_done;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      wait (!reset);
      forever begin
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each accepted result beat with the oldest pending distance
   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready)
         input_stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (distance_due.size() == 0) begin
            $error("distance: no result pending, got %0d", rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== distance_due[0]) begin
               $error("distance: expected %0d, got %0d", distance_due[0], rsp_tdata);
               fail_count++;
            end
            if (distance_due[0] == 0)
               zero_count++;
            void'(distance_due.pop_front());
            checked_count++;
         end
      end
   end

   // Hard limit on run time
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ihyp_pkg.sv
rtl/core/integer_hypotenuse.sv
sim/integer_hypotenuse_test.sv
